// File: design/scvg_pkg.sv
// Shared types, constants and helpers of the sphere cell vertex generator.
`default_nettype none
package scvg_pkg;

    localparam int INDEX_BITS   = 10;
    localparam int PHASE_BITS   = 16;
    localparam int CORDIC_ITERS = 28;
    localparam int CW           = 34;   // CORDIC datapath width
    localparam int SW           = 33;   // sine / cosine result width
    localparam int CFG_IDX_BITS = 3;

    // Keep the top PHASE_BITS of the 16-bit phase, clear the rest.
    localparam logic [15:0] PHASE_KEEP = (PHASE_BITS >= 16) ? 16'hFFFF :
        16'(17'h10000 - (17'd1 << (16 - PHASE_BITS)));

    localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

    localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
        CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
        CW'(42667331), CW'(21354465), CW'(10679838), CW'(5340245),
        CW'(2670163), CW'(1335087), CW'(667544), CW'(333772), CW'(166886),
        CW'(83443), CW'(41722), CW'(20861), CW'(10430), CW'(5215), CW'(2608),
        CW'(1304), CW'(652), CW'(326), CW'(163), CW'(81), CW'(41), CW'(20),
        CW'(10), CW'(5)
    };

    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_THETA_ST = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PHI_ST   = 3'd5;

    localparam logic [1:0] CORNER_00 = 2'd0;
    localparam logic [1:0] CORNER_10 = 2'd1;
    localparam logic [1:0] CORNER_01 = 2'd2;
    localparam logic [1:0] CORNER_11 = 2'd3;

    typedef struct packed {
        logic [INDEX_BITS-1:0] theta_index;
        logic [INDEX_BITS-1:0] phi_index;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic [1:0]         corner_code;
        logic               last_vertex;
    } out_item_t;

    typedef struct packed {
        logic [1:0] corner_code;
        logic       last_vertex;
    } meta_t;

    typedef struct packed {
        logic [31:0] theta_angle;
        logic [31:0] phi_angle;
        meta_t       meta;
    } beat_t;

    typedef struct packed {
        logic signed [SW-1:0] st;
        logic signed [SW-1:0] ct;
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] cp;
        meta_t                meta;
    } trig_t;

    // Corner visited on each of the six beats of a cell: 00,10,01,01,10,11.
    function automatic meta_t beat_meta(input logic [2:0] beat);
        meta_t m;
        m.last_vertex = 1'b0;
        unique case (beat)
            3'd0:    m.corner_code = CORNER_00;
            3'd1:    m.corner_code = CORNER_10;
            3'd2:    m.corner_code = CORNER_01;
            3'd3:    m.corner_code = CORNER_01;
            3'd4:    m.corner_code = CORNER_10;
            3'd5:
            begin
                m.corner_code = CORNER_11;
                m.last_vertex = 1'b1;
            end
            default: m.corner_code = CORNER_00;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: design/scvg_expand.sv
// Cell expander: holds one cell and issues its six corner beats with angles.
`default_nettype none
module scvg_expand
    import scvg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    input  wire logic [15:0] theta_step,
    input  wire logic [15:0] phi_step,
    output logic             beat_valid,
    output beat_t            beat
);

    logic       busy_reg, busy_next;
    logic [2:0] cnt_reg, cnt_next;
    in_item_t   item_reg;
    logic       bvalid_reg;
    beat_t      beat_reg, beat_next;

    meta_t                   m;
    logic [INDEX_BITS:0]     t_idx, p_idx;
    logic [INDEX_BITS+16:0]  t_prod, p_prod;
    logic                    last_beat, accept;

    always_comb
    begin
        m      = beat_meta(cnt_reg);
        t_idx  = {1'b0, item_reg.theta_index} + (INDEX_BITS+1)'(m.corner_code[0]);
        p_idx  = {1'b0, item_reg.phi_index} + (INDEX_BITS+1)'(m.corner_code[1]);
        t_prod = (INDEX_BITS+17)'(t_idx) * (INDEX_BITS+17)'(theta_step);
        p_prod = (INDEX_BITS+17)'(p_idx) * (INDEX_BITS+17)'(phi_step);
        beat_next.theta_angle = {t_prod[15:0] & PHASE_KEEP, 16'h0000};
        beat_next.phi_angle   = {p_prod[15:0] & PHASE_KEEP, 16'h0000};
        beat_next.meta        = m;
    end

    assign last_beat = adv && busy_reg && (cnt_reg == 3'd5);
    assign in_ready  = !busy_reg || last_beat;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (adv && busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (last_beat)
            begin
                busy_next = 1'b0;
                cnt_next  = 3'd0;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            bvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (adv)
            begin
                bvalid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_valid = bvalid_reg;
    assign beat       = beat_reg;

    ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && cnt_reg == 3'd0)
        else $error("cell not held after accept");
    ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 3'd5)
        else $error("beat counter out of range");
    ap_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 3'd0)
        else $error("beat counter not cleared when idle");

endmodule
`default_nettype wire

// File: design/scvg_cordic.sv
// Two-lane pipelined rotation CORDIC: sine and cosine of theta and phi.
`default_nettype none
module scvg_cordic
    import scvg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  beat_valid,
    input  wire beat_t beat,
    output logic       trig_valid,
    output trig_t      trig
);

    localparam int LAST = CORDIC_ITERS;

    logic signed [CW-1:0] x_reg [0:LAST][0:1];
    logic signed [CW-1:0] y_reg [0:LAST][0:1];
    logic signed [CW-1:0] z_reg [0:LAST][0:1];
    logic                 neg_reg [0:LAST][0:1];
    meta_t                meta_reg [0:LAST];
    logic                 vld_reg [0:LAST];
    logic                 out_vld_reg;
    trig_t                out_reg, out_next;

    logic signed [CW-1:0] z_in [0:1];
    logic signed [CW-1:0] z_fold [0:1];
    logic                 neg_in [0:1];

    localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] HALF    = CW'(64'sd2147483648);

    // Fold into [-1/4, 1/4] turn; remember to negate the results.
    always_comb
    begin
        z_in[0] = CW'($signed(beat.theta_angle));
        z_in[1] = CW'($signed(beat.phi_angle));
        for (int l = 0; l < 2; l++)
        begin
            z_fold[l] = z_in[l];
            neg_in[l] = 1'b0;
            if (z_in[l] > QUARTER)
            begin
                z_fold[l] = z_in[l] - HALF;
                neg_in[l] = 1'b1;
            end
            else if (z_in[l] < -QUARTER)
            begin
                z_fold[l] = z_in[l] + HALF;
                neg_in[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= beat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= beat.meta;
            for (int l = 0; l < 2; l++)
            begin
                x_reg[0][l]   <= CORDIC_X0;
                y_reg[0][l]   <= '0;
                z_reg[0][l]   <= z_fold[l];
                neg_reg[0][l] <= neg_in[l];
            end
        end
    end

    for (genvar i = 0; i < LAST; i++)
    begin : g_iter
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                meta_reg[i+1] <= meta_reg[i];
                for (int l = 0; l < 2; l++)
                begin
                    neg_reg[i+1][l] <= neg_reg[i][l];
                    if (!z_reg[i][l][CW-1])
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] - ATAN_TURNS[i];
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] + ATAN_TURNS[i];
                    end
                end
            end
        end
    end

    // Undo the fold and drop the spare top bit.
    always_comb
    begin
        out_next.st = SW'(neg_reg[LAST][0] ? -y_reg[LAST][0] : y_reg[LAST][0]);
        out_next.ct = SW'(neg_reg[LAST][0] ? -x_reg[LAST][0] : x_reg[LAST][0]);
        out_next.sp = SW'(neg_reg[LAST][1] ? -y_reg[LAST][1] : y_reg[LAST][1]);
        out_next.cp = SW'(neg_reg[LAST][1] ? -x_reg[LAST][1] : x_reg[LAST][1]);
        out_next.meta = meta_reg[LAST];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign trig_valid = out_vld_reg;
    assign trig       = out_reg;

    ap_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> z_reg[0][0] <= QUARTER && z_reg[0][0] >= -QUARTER)
        else $error("theta fold out of range");
    ap_fold_phi: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> z_reg[0][1] <= QUARTER && z_reg[0][1] >= -QUARTER)
        else $error("phi fold out of range");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(out_vld_reg))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// File: design/scvg_vertex.sv
// Vertex builder: direction products, radius scale, center add and saturation.
`default_nettype none
module scvg_vertex
    import scvg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               trig_valid,
    input  wire trig_t              trig,
    input  wire logic        [30:0] sphere_radius,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    output logic                    out_valid,
    output out_item_t               out_data
);

    localparam logic signed [65:0] RND66 = 66'sd536870912;
    localparam logic signed [64:0] RND65 = 65'sd536870912;

    logic [3:0] vld_reg;

    // stage 1: direction products
    logic signed [65:0] px_reg, py_reg;
    logic signed [SW-1:0] cp1_reg;
    meta_t m1_reg;
    // stage 2: round to Q30
    logic signed [SW-1:0] dx_reg, dy_reg, cp2_reg;
    meta_t m2_reg;
    // stage 3: radius scale
    logic signed [64:0] qx_reg, qy_reg, qz_reg;
    meta_t m3_reg;
    // stage 4: result
    out_item_t res_reg, res_next;

    logic signed [31:0] rs;

    function automatic logic signed [31:0] sat_add(input logic signed [64:0] q,
                                                   input logic signed [31:0] c);
        logic signed [64:0] t;
        logic signed [34:0] s;
        t = (q + RND65) >>> 30;
        s = 35'(t) + 35'(c);
        if (s > 35'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (s < -35'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return 32'(s);
    endfunction

    assign rs = {1'b0, sphere_radius};

    always_comb
    begin
        res_next.vertex_x    = sat_add(qx_reg, center_x);
        res_next.vertex_y    = sat_add(qy_reg, center_y);
        res_next.vertex_z    = sat_add(qz_reg, center_z);
        res_next.corner_code = m3_reg.corner_code;
        res_next.last_vertex = m3_reg.last_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], trig_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= 66'(trig.ct) * 66'(trig.sp);
            py_reg  <= 66'(trig.st) * 66'(trig.sp);
            cp1_reg <= trig.cp;
            m1_reg  <= trig.meta;

            dx_reg  <= SW'((px_reg + RND66) >>> 30);
            dy_reg  <= SW'((py_reg + RND66) >>> 30);
            cp2_reg <= cp1_reg;
            m2_reg  <= m1_reg;

            qx_reg  <= 65'(rs) * 65'(dx_reg);
            qy_reg  <= 65'(rs) * 65'(dy_reg);
            qz_reg  <= 65'(rs) * 65'(cp2_reg);
            m3_reg  <= m2_reg;

            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = res_reg;

    ap_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_vertex |-> out_data.corner_code == CORNER_11)
        else $error("last vertex is not corner 11");
    ap_corner_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.corner_code == CORNER_11 |-> out_data.last_vertex)
        else $error("corner 11 without last flag");
    ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("vertex stages moved while stalled");

endmodule
`default_nettype wire

// File: design/sphere_cell_vertex_generator.sv
// Top level of the sphere cell vertex generator: config registers and pipeline.
`default_nettype none
// Takes one grid cell (longitude and latitude index) per input beat and returns
// six vertex beats, the two triangles 00,10,01 and 01,10,11 of the cell, each
// center + radius * (cos t sin p, sin t sin p, cos p) in saturated Q16.16.
// The cell expander issues one corner per cycle while adv is high, into a
// pipeline that takes a new corner every cycle unless a low out_ready stalls
// it; a new cell is also accepted in the cycle its sixth corner issues.
// From cell accept to first vertex valid a corner passes 1 expander stage,
// 30 CORDIC stages (fold, 28 iterations, output) and 4 vertex stages. A low
// out_ready with out_valid high freezes the whole pipeline; nothing is lost.
// Indexes 6 and 7 are ignored. Registers are to be written through cfg_we /
// cfg_index / cfg_data only while the block is idle, which it does not enforce.
module sphere_cell_vertex_generator
    import scvg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire in_item_t                in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output out_item_t                    out_data,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]             cfg_data
);

    logic        [30:0] radius_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic        [15:0] tstep_reg, pstep_reg;

    logic  adv;
    logic  beat_valid;
    beat_t beat;
    logic  trig_valid;
    trig_t trig;

    // Advance every stage whenever the output register is free or draining.
    assign adv = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            tstep_reg  <= 16'd4096;
            pstep_reg  <= 16'd2048;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:   radius_reg <= cfg_data[30:0];
                REG_CENTER_X: cx_reg     <= $signed(cfg_data);
                REG_CENTER_Y: cy_reg     <= $signed(cfg_data);
                REG_CENTER_Z: cz_reg     <= $signed(cfg_data);
                REG_THETA_ST: tstep_reg  <= cfg_data[15:0];
                REG_PHI_ST:   pstep_reg  <= cfg_data[15:0];
                default:      ;  // drop writes beyond the register list
            endcase
        end
    end

    scvg_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .theta_step (tstep_reg),
        .phi_step   (pstep_reg),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    scvg_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .beat_valid (beat_valid),
        .beat       (beat),
        .trig_valid (trig_valid),
        .trig       (trig)
    );

    scvg_vertex u_vertex (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .trig_valid    (trig_valid),
        .trig          (trig),
        .sphere_radius (radius_reg),
        .center_x      (cx_reg),
        .center_y      (cy_reg),
        .center_z      (cz_reg),
        .out_valid     (out_valid),
        .out_data      (out_data)
    );

    // One cell in flight at the expander: a fresh accept blocks the next cycle.
    ap_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two cells accepted back to back");
    ap_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("vertex dropped under stall");
    ap_first_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.corner_code == CORNER_00 |-> !out_data.last_vertex)
        else $error("corner 00 flagged as last");

endmodule
`default_nettype wire
